// ===== src/gn2d_pkg.sv =====
// Package: shared types, constants and lookup tables for the 2D gradient noise core.
`default_nettype none
package gn2d_pkg;

	localparam int unsigned GRAD_ONE  = 32768;
	localparam int unsigned GRAD_DIAG = 23170;
	localparam int unsigned SQRT2_Q15 = 46341;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned FADE_ONE  = 65536;

	// dot product range: |g|<=32768, |d|<=65536, two terms -> fits 36 bits signed
	localparam int unsigned DOT_W = 36;

	typedef logic [7:0] cell_t;
	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [16:0] fade_t;
	typedef logic signed [DOT_W-1:0] dot_t;

	// classified item handed from the front part to the back part
	typedef struct packed {
		cell_t cx;
		cell_t cy;
		frac_t fx;
		frac_t fy;
	} item_t;

	function automatic cell_t perm(input cell_t i);
		cell_t r;
		case (i)
			8'd0: r = 8'd23; 8'd1: r = 8'd125; 8'd2: r = 8'd161; 8'd3: r = 8'd52;
			8'd4: r = 8'd103; 8'd5: r = 8'd117; 8'd6: r = 8'd70; 8'd7: r = 8'd37;
			8'd8: r = 8'd247; 8'd9: r = 8'd101; 8'd10: r = 8'd203; 8'd11: r = 8'd169;
			8'd12: r = 8'd124; 8'd13: r = 8'd126; 8'd14: r = 8'd44; 8'd15: r = 8'd123;
			8'd16: r = 8'd152; 8'd17: r = 8'd238; 8'd18: r = 8'd145; 8'd19: r = 8'd45;
			8'd20: r = 8'd171; 8'd21: r = 8'd114; 8'd22: r = 8'd253; 8'd23: r = 8'd10;
			8'd24: r = 8'd192; 8'd25: r = 8'd136; 8'd26: r = 8'd4; 8'd27: r = 8'd157;
			8'd28: r = 8'd249; 8'd29: r = 8'd30; 8'd30: r = 8'd35; 8'd31: r = 8'd72;
			8'd32: r = 8'd175; 8'd33: r = 8'd63; 8'd34: r = 8'd77; 8'd35: r = 8'd90;
			8'd36: r = 8'd181; 8'd37: r = 8'd16; 8'd38: r = 8'd96; 8'd39: r = 8'd111;
			8'd40: r = 8'd133; 8'd41: r = 8'd104; 8'd42: r = 8'd75; 8'd43: r = 8'd162;
			8'd44: r = 8'd93; 8'd45: r = 8'd56; 8'd46: r = 8'd66; 8'd47: r = 8'd240;
			8'd48: r = 8'd8; 8'd49: r = 8'd50; 8'd50: r = 8'd84; 8'd51: r = 8'd229;
			8'd52: r = 8'd49; 8'd53: r = 8'd210; 8'd54: r = 8'd173; 8'd55: r = 8'd239;
			8'd56: r = 8'd141; 8'd57: r = 8'd1; 8'd58: r = 8'd87; 8'd59: r = 8'd18;
			8'd60: r = 8'd2; 8'd61: r = 8'd198; 8'd62: r = 8'd143; 8'd63: r = 8'd57;
			8'd64: r = 8'd225; 8'd65: r = 8'd160; 8'd66: r = 8'd58; 8'd67: r = 8'd217;
			8'd68: r = 8'd168; 8'd69: r = 8'd206; 8'd70: r = 8'd245; 8'd71: r = 8'd204;
			8'd72: r = 8'd199; 8'd73: r = 8'd6; 8'd74: r = 8'd73; 8'd75: r = 8'd60;
			8'd76: r = 8'd20; 8'd77: r = 8'd230; 8'd78: r = 8'd211; 8'd79: r = 8'd233;
			8'd80: r = 8'd94; 8'd81: r = 8'd200; 8'd82: r = 8'd88; 8'd83: r = 8'd9;
			8'd84: r = 8'd74; 8'd85: r = 8'd155; 8'd86: r = 8'd33; 8'd87: r = 8'd15;
			8'd88: r = 8'd219; 8'd89: r = 8'd130; 8'd90: r = 8'd226; 8'd91: r = 8'd202;
			8'd92: r = 8'd83; 8'd93: r = 8'd236; 8'd94: r = 8'd42; 8'd95: r = 8'd172;
			8'd96: r = 8'd165; 8'd97: r = 8'd218; 8'd98: r = 8'd55; 8'd99: r = 8'd222;
			8'd100: r = 8'd46; 8'd101: r = 8'd107; 8'd102: r = 8'd98; 8'd103: r = 8'd154;
			8'd104: r = 8'd109; 8'd105: r = 8'd67; 8'd106: r = 8'd196; 8'd107: r = 8'd178;
			8'd108: r = 8'd127; 8'd109: r = 8'd158; 8'd110: r = 8'd13; 8'd111: r = 8'd243;
			8'd112: r = 8'd65; 8'd113: r = 8'd79; 8'd114: r = 8'd166; 8'd115: r = 8'd248;
			8'd116: r = 8'd25; 8'd117: r = 8'd224; 8'd118: r = 8'd115; 8'd119: r = 8'd80;
			8'd120: r = 8'd68; 8'd121: r = 8'd51; 8'd122: r = 8'd184; 8'd123: r = 8'd128;
			8'd124: r = 8'd232; 8'd125: r = 8'd208; 8'd126: r = 8'd151; 8'd127: r = 8'd122;
			8'd128: r = 8'd26; 8'd129: r = 8'd212; 8'd130: r = 8'd105; 8'd131: r = 8'd43;
			8'd132: r = 8'd179; 8'd133: r = 8'd213; 8'd134: r = 8'd235; 8'd135: r = 8'd148;
			8'd136: r = 8'd146; 8'd137: r = 8'd89; 8'd138: r = 8'd14; 8'd139: r = 8'd195;
			8'd140: r = 8'd28; 8'd141: r = 8'd78; 8'd142: r = 8'd112; 8'd143: r = 8'd76;
			8'd144: r = 8'd250; 8'd145: r = 8'd47; 8'd146: r = 8'd24; 8'd147: r = 8'd251;
			8'd148: r = 8'd140; 8'd149: r = 8'd108; 8'd150: r = 8'd186; 8'd151: r = 8'd190;
			8'd152: r = 8'd228; 8'd153: r = 8'd170; 8'd154: r = 8'd183; 8'd155: r = 8'd139;
			8'd156: r = 8'd39; 8'd157: r = 8'd188; 8'd158: r = 8'd244; 8'd159: r = 8'd246;
			8'd160: r = 8'd132; 8'd161: r = 8'd48; 8'd162: r = 8'd119; 8'd163: r = 8'd144;
			8'd164: r = 8'd180; 8'd165: r = 8'd138; 8'd166: r = 8'd134; 8'd167: r = 8'd193;
			8'd168: r = 8'd82; 8'd169: r = 8'd182; 8'd170: r = 8'd120; 8'd171: r = 8'd121;
			8'd172: r = 8'd86; 8'd173: r = 8'd220; 8'd174: r = 8'd209; 8'd175: r = 8'd3;
			8'd176: r = 8'd91; 8'd177: r = 8'd241; 8'd178: r = 8'd149; 8'd179: r = 8'd85;
			8'd180: r = 8'd205; 8'd181: r = 8'd150; 8'd182: r = 8'd113; 8'd183: r = 8'd216;
			8'd184: r = 8'd31; 8'd185: r = 8'd100; 8'd186: r = 8'd41; 8'd187: r = 8'd164;
			8'd188: r = 8'd177; 8'd189: r = 8'd214; 8'd190: r = 8'd153; 8'd191: r = 8'd231;
			8'd192: r = 8'd38; 8'd193: r = 8'd71; 8'd194: r = 8'd185; 8'd195: r = 8'd174;
			8'd196: r = 8'd97; 8'd197: r = 8'd201; 8'd198: r = 8'd29; 8'd199: r = 8'd95;
			8'd200: r = 8'd7; 8'd201: r = 8'd92; 8'd202: r = 8'd54; 8'd203: r = 8'd254;
			8'd204: r = 8'd191; 8'd205: r = 8'd118; 8'd206: r = 8'd34; 8'd207: r = 8'd221;
			8'd208: r = 8'd131; 8'd209: r = 8'd11; 8'd210: r = 8'd163; 8'd211: r = 8'd99;
			8'd212: r = 8'd234; 8'd213: r = 8'd81; 8'd214: r = 8'd227; 8'd215: r = 8'd147;
			8'd216: r = 8'd156; 8'd217: r = 8'd176; 8'd218: r = 8'd17; 8'd219: r = 8'd142;
			8'd220: r = 8'd69; 8'd221: r = 8'd12; 8'd222: r = 8'd110; 8'd223: r = 8'd62;
			8'd224: r = 8'd27; 8'd225: r = 8'd255; 8'd226: r = 8'd0; 8'd227: r = 8'd194;
			8'd228: r = 8'd59; 8'd229: r = 8'd116; 8'd230: r = 8'd242; 8'd231: r = 8'd252;
			8'd232: r = 8'd19; 8'd233: r = 8'd21; 8'd234: r = 8'd187; 8'd235: r = 8'd53;
			8'd236: r = 8'd207; 8'd237: r = 8'd129; 8'd238: r = 8'd64; 8'd239: r = 8'd135;
			8'd240: r = 8'd61; 8'd241: r = 8'd40; 8'd242: r = 8'd167; 8'd243: r = 8'd237;
			8'd244: r = 8'd102; 8'd245: r = 8'd223; 8'd246: r = 8'd106; 8'd247: r = 8'd159;
			8'd248: r = 8'd197; 8'd249: r = 8'd189; 8'd250: r = 8'd215; 8'd251: r = 8'd137;
			8'd252: r = 8'd36; 8'd253: r = 8'd32; 8'd254: r = 8'd22; default: r = 8'd5;
		endcase
		return r;
	endfunction

	// dot of gradient g with offset (dx, dy); dx, dy are signed 18-bit Q.16
	function automatic dot_t grad_dot(input logic [2:0] g, input logic signed [17:0] dx,
		input logic signed [17:0] dy);
		dot_t ex, ey, dg;
		ex = dot_t'(dx) <<< 15;
		ey = dot_t'(dy) <<< 15;
		dg = dot_t'(dx + dy) * dot_t'(GRAD_DIAG);
		case (g)
			3'd0: grad_dot = ex;
			3'd1: grad_dot = -ex;
			3'd2: grad_dot = ey;
			3'd3: grad_dot = -ey;
			3'd4: grad_dot = dg;
			3'd5: grad_dot = dot_t'(dy - dx) * dot_t'(GRAD_DIAG);
			3'd6: grad_dot = dot_t'(dx - dy) * dot_t'(GRAD_DIAG);
			default: grad_dot = -dg;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== src/gn2d_front.sv =====
// Front part: scales the point by the frequency and splits it into cells and fractions.
`default_nettype none
module gn2d_front #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic signed [31:0]   x_coord,
	input  wire logic signed [31:0]   y_coord,
	input  wire logic [15:0]          freq_scale,
	output logic                      out_valid,
	output gn2d_pkg::item_t           out_item
);
	logic                valid_s1;
	logic signed [48:0]  px_s1, py_s1;
	logic signed [48:0]  px_sh, py_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= 49'(x_coord) * $signed({1'b0, freq_scale});
		py_s1 <= 49'(y_coord) * $signed({1'b0, freq_scale});
	end

	// floor shift by 8 keeps FRAC_BITS fraction bits
	assign px_sh = px_s1 >>> 8;
	assign py_sh = py_s1 >>> 8;

	function automatic gn2d_pkg::frac_t to_q16(input logic signed [48:0] p);
		logic [23:0] t24;
		logic [FRAC_BITS-1:0] t;
		t = p[FRAC_BITS-1:0];
		t24 = 24'(t) << (24 - FRAC_BITS);
		return t24[23:8];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_item.cx <= px_sh[FRAC_BITS+7:FRAC_BITS];
		out_item.cy <= py_sh[FRAC_BITS+7:FRAC_BITS];
		out_item.fx <= to_q16(px_sh);
		out_item.fy <= to_q16(py_sh);
	end
endmodule
`default_nettype wire

// ===== src/gn2d_fifo.sv =====
// Short queue between the front and back parts.
`default_nettype none
module gn2d_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire gn2d_pkg::item_t wr_data,
	input  wire logic            rd_en,
	output logic                 rd_valid,
	output gn2d_pkg::item_t      rd_data
);
	gn2d_pkg::item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign rd_valid = (cnt_q != 3'd0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (rd_en && rd_valid) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr_en) - 3'(rd_en && rd_valid);
		end
	end
endmodule
`default_nettype wire

// ===== src/gn2d_back.sv =====
// Back part: hashes corners, takes gradient dots, fades, blends and scales.
`default_nettype none
module gn2d_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire gn2d_pkg::item_t    in_item,
	output logic                    out_valid,
	output logic signed [15:0]      noise_value
);
	// stage 1: hashes and fade powers u^2
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [2:0]  g00_s1, g10_s1, g01_s1, g11_s1;
	gn2d_pkg::frac_t fx_s1, fy_s1, ux2_s1, uy2_s1;
	logic [31:0] mx, my;
	logic [7:0]  hx0, hx1, cy1;

	assign hx0 = gn2d_pkg::perm(in_item.cx);
	assign hx1 = gn2d_pkg::perm(in_item.cx + 8'd1);
	assign cy1 = in_item.cy + 8'd1;
	assign mx  = in_item.fx * in_item.fx;
	assign my  = in_item.fy * in_item.fy;

	always_ff @(posedge clk) begin
		g00_s1 <= 3'(gn2d_pkg::perm(hx0 + in_item.cy));
		g10_s1 <= 3'(gn2d_pkg::perm(hx1 + in_item.cy));
		g01_s1 <= 3'(gn2d_pkg::perm(hx0 + cy1));
		g11_s1 <= 3'(gn2d_pkg::perm(hx1 + cy1));
		fx_s1  <= in_item.fx;
		fy_s1  <= in_item.fy;
		ux2_s1 <= mx[31:16];
		uy2_s1 <= my[31:16];
	end

	// stage 2: dots and u^3
	gn2d_pkg::dot_t d00_s2, d10_s2, d01_s2, d11_s2;
	gn2d_pkg::frac_t fx_s2, fy_s2, ux3_s2, uy3_s2;
	logic signed [17:0] dx0, dy0, dx1, dy1;
	logic [31:0] mx3, my3;

	assign dx0 = 18'(fx_s1);
	assign dy0 = 18'(fy_s1);
	assign dx1 = dx0 - 18'sd65536;
	assign dy1 = dy0 - 18'sd65536;
	assign mx3 = ux2_s1 * fx_s1;
	assign my3 = uy2_s1 * fy_s1;

	always_ff @(posedge clk) begin
		d00_s2 <= gn2d_pkg::grad_dot(g00_s1, dx0, dy0);
		d10_s2 <= gn2d_pkg::grad_dot(g10_s1, dx1, dy0);
		d01_s2 <= gn2d_pkg::grad_dot(g01_s1, dx0, dy1);
		d11_s2 <= gn2d_pkg::grad_dot(g11_s1, dx1, dy1);
		fx_s2  <= fx_s1;
		fy_s2  <= fy_s1;
		ux3_s2 <= mx3[31:16];
		uy3_s2 <= my3[31:16];
	end

	// stage 3: u^4
	gn2d_pkg::dot_t d00_s3, d10_s3, d01_s3, d11_s3;
	gn2d_pkg::frac_t fx_s3, fy_s3, ux3_s3, uy3_s3, ux4_s3, uy4_s3;
	logic [31:0] mx4, my4;
	assign mx4 = ux3_s2 * fx_s2;
	assign my4 = uy3_s2 * fy_s2;

	always_ff @(posedge clk) begin
		d00_s3 <= d00_s2; d10_s3 <= d10_s2; d01_s3 <= d01_s2; d11_s3 <= d11_s2;
		fx_s3 <= fx_s2; fy_s3 <= fy_s2;
		ux3_s3 <= ux3_s2; uy3_s3 <= uy3_s2;
		ux4_s3 <= mx4[31:16]; uy4_s3 <= my4[31:16];
	end

	// stage 4: u^5 and fade sum with clamp
	gn2d_pkg::dot_t d00_s4, d10_s4, d01_s4, d11_s4;
	gn2d_pkg::fade_t tx_s4, ty_s4;
	logic [31:0] mx5, my5;
	logic signed [21:0] sx, sy;
	assign mx5 = ux4_s3 * fx_s3;
	assign my5 = uy4_s3 * fy_s3;

	function automatic gn2d_pkg::fade_t fade_clamp(input logic signed [21:0] f);
		if (f < 22'sd0) return '0;
		if (f > 22'sd65536) return 17'd65536;
		return f[16:0];
	endfunction

	assign sx = 22'sd10 * $signed({6'd0, ux3_s3}) - 22'sd15 * $signed({6'd0, ux4_s3})
		+ 22'sd6 * $signed({6'd0, mx5[31:16]});
	assign sy = 22'sd10 * $signed({6'd0, uy3_s3}) - 22'sd15 * $signed({6'd0, uy4_s3})
		+ 22'sd6 * $signed({6'd0, my5[31:16]});

	always_ff @(posedge clk) begin
		d00_s4 <= d00_s3; d10_s4 <= d10_s3; d01_s4 <= d01_s3; d11_s4 <= d11_s3;
		tx_s4 <= fade_clamp(sx);
		ty_s4 <= fade_clamp(sy);
	end

	// stage 5: blend along x
	gn2d_pkg::dot_t lo_s5, hi_s5;
	gn2d_pkg::fade_t ty_s5;
	logic signed [54:0] px0, px1;
	assign px0 = 55'(d10_s4 - d00_s4) * $signed({1'b0, tx_s4});
	assign px1 = 55'(d11_s4 - d01_s4) * $signed({1'b0, tx_s4});

	always_ff @(posedge clk) begin
		lo_s5 <= d00_s4 + gn2d_pkg::dot_t'(px0 >>> 16);
		hi_s5 <= d01_s4 + gn2d_pkg::dot_t'(px1 >>> 16);
		ty_s5 <= ty_s4;
	end

	// stage 6: blend along y
	gn2d_pkg::dot_t val_s6;
	logic signed [54:0] py;
	assign py = 55'(hi_s5 - lo_s5) * $signed({1'b0, ty_s5});

	always_ff @(posedge clk) begin
		val_s6 <= lo_s5 + gn2d_pkg::dot_t'(py >>> 16);
	end

	// stage 7: scale by sqrt 2, round, saturate
	logic signed [53:0] sc;
	logic signed [21:0] r;
	assign sc = 54'(val_s6) * 54'sd46341 + 54'sd2147483648;
	assign r  = 22'(sc >>> 32);

	always_ff @(posedge clk) begin
		if (r > 22'sd32767) noise_value <= 16'sh7fff;
		else if (r < -22'sd32768) noise_value <= 16'sh8000;
		else noise_value <= r[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	assign out_valid = v_s7;
endmodule
`default_nettype wire

// ===== src/gradient_noise_2d_core.sv =====
// Top level: 2D gradient noise core, one point in and one Q2.14 sample out.
// Path from start to done: 2 front stages, 1 queue, 7 back stages.
// Throughput: one point per cycle; busy stays low, the back part never stalls.
// The receiver cannot stall; done is a one-cycle strobe with noise_value.
// Reset: arst_n clears all valid flags and sets freq_scale to 1.0 (256).
`default_nettype none
module gradient_noise_2d_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic signed [31:0]  x_coord,
	input  wire logic signed [31:0]  y_coord,
	input  wire logic                cfg_we,
	input  wire logic [15:0]         cfg_wdata,
	output logic                     done,
	output logic signed [15:0]       noise_value
);
	logic [15:0]     freq_scale_q;
	logic            f_valid, q_valid;
	gn2d_pkg::item_t f_item, q_item;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_scale_q <= 16'd256;
		end else if (cfg_we) begin
			freq_scale_q <= cfg_wdata;
		end
	end

	gn2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid(start), .x_coord, .y_coord,
		.freq_scale(freq_scale_q), .out_valid(f_valid), .out_item(f_item)
	);

	gn2d_fifo u_fifo (
		.clk, .arst_n, .wr_en(f_valid), .wr_data(f_item),
		.rd_en(1'b1), .rd_valid(q_valid), .rd_data(q_item)
	);

	gn2d_back u_back (
		.clk, .arst_n, .in_valid(q_valid), .in_item(q_item),
		.out_valid(done), .noise_value
	);
endmodule
`default_nettype wire
